>>> hdl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types for the huffman code bit packer
// command codes and the packed input and result transaction formats
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int CODE_WIDTH = 16;
  localparam int BYTE_WIDTH = 8;
  localparam int LEN_WIDTH  = 5;
  localparam int SYM_WIDTH  = 8;
  localparam int PAD_WIDTH  = 3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [SYM_WIDTH-1:0]  symbol;
    logic [CODE_WIDTH-1:0] code_bits;
    logic [LEN_WIDTH-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0] out_byte;
    logic [PAD_WIDTH-1:0]  pad_bits;
    logic                  last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hdl/huffman_code_bit_packer_core.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core: huffman encoder back end
// code table in one synchronous memory, byte packer, two-entry result buffer
// ----------------------------------------------------------------------------
// results pass through the stage 1 registers and then the result buffer
// flow: stage 0 accepts a new transaction as stage 1 moves on; an encode
//   giving two bytes waits for an empty result buffer, set by the one-byte
//   result port draining the two-entry result buffer
// reset: rst (synchronous) clears the pipeline, the result buffer and the
//   pending bits; the code table is not cleared and needs no clearing pass
`default_nettype none

module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_LEN = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  hcbp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hcbp_pkg::out_item_t  out_item
);

  import hcbp_pkg::*;

  // table geometry and the saturation bound for loaded lengths
  localparam int AW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_WIDTH) ? MAX_CODE_LEN : CODE_WIDTH;
  localparam int ACC_W   = CODE_WIDTH + BYTE_WIDTH;
  localparam int ENTRY_W = CODE_WIDTH + LEN_WIDTH;

  localparam logic [LEN_WIDTH-1:0]   LEN_CAP_V = LEN_CAP[LEN_WIDTH-1:0];
  localparam logic [SYM_WIDTH:0]     SYM_LIMIT = SYMBOL_COUNT[SYM_WIDTH:0];
  localparam logic [LEN_WIDTH-1:0]   CODE_W_V  = CODE_WIDTH[LEN_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // stage 0: accept, table write for loads, table read for everything
  // ---------------------------------------------------------------------------
  logic                  in_acc;
  logic                  in_sym_ok;
  logic [AW-1:0]         in_addr;
  logic [LEN_WIDTH-1:0]  load_len;
  logic [CODE_WIDTH-1:0] load_mask;
  logic [ENTRY_W-1:0]    load_entry;

  assign in_acc    = in_valid && in_ready;
  assign in_sym_ok = {1'b0, in_item.symbol} < SYM_LIMIT;
  assign in_addr   = in_item.symbol[AW-1:0];

  // saturate the length and keep only the code bits it covers
  always_comb begin
    load_len = (in_item.code_length > LEN_CAP_V) ? LEN_CAP_V : in_item.code_length;
    for (int i = 0; i < CODE_WIDTH; i++) begin
      load_mask[i] = (i < int'(load_len));
    end
    load_entry = {in_item.code_bits & load_mask, load_len};
  end

  // code table: one write port, one registered read port
  logic [ENTRY_W-1:0] table_mem [SYMBOL_COUNT];
  logic [ENTRY_W-1:0] rd_entry;

  always_ff @(posedge clk) begin
    if (in_acc && (in_item.cmd == CMD_LOAD) && in_sym_ok) begin
      table_mem[in_addr] <= load_entry;
    end
    // read data holds while stage 1 is stalled
    if (in_acc) begin
      rd_entry <= table_mem[in_addr];
    end
  end

  // stage 1 control, aligned with the table read data
  logic s1_valid;
  cmd_t s1_cmd;
  logic s1_sym_ok;
  logic s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd    <= in_item.cmd;
      s1_sym_ok <= in_sym_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: bit packing against the pending partial byte
  // ---------------------------------------------------------------------------
  logic [BYTE_WIDTH-1:0] partial_byte, partial_byte_next;
  logic [PAD_WIDTH-1:0]  filled_bits, filled_bits_next;

  logic [CODE_WIDTH-1:0] rd_code;
  logic [LEN_WIDTH-1:0]  rd_len;
  logic [ACC_W-1:0]      code_aligned;
  logic [ACC_W-1:0]      acc_word;
  logic [ACC_W-1:0]      acc_rest;
  logic [LEN_WIDTH-1:0]  total_bits;
  logic [1:0]            n_res;
  out_item_t             res0, res1;

  assign rd_code = rd_entry[ENTRY_W-1:LEN_WIDTH];
  assign rd_len  = rd_entry[LEN_WIDTH-1:0];

  always_comb begin
    // new code placed right after the pending bits, MSB first
    code_aligned = ({rd_code, {BYTE_WIDTH{1'b0}}} << (CODE_W_V - rd_len)) >> filled_bits;
    acc_word     = {partial_byte, {CODE_WIDTH{1'b0}}} | code_aligned;
    total_bits   = {2'b00, filled_bits} + rd_len;

    n_res             = 2'd0;
    res0              = '0;
    res1              = '0;
    partial_byte_next = partial_byte;
    filled_bits_next  = filled_bits;
    acc_rest          = acc_word;

    unique case (s1_cmd)
      CMD_ENCODE: begin
        if (s1_sym_ok) begin
          n_res            = total_bits[4:3];
          acc_rest         = acc_word << {total_bits[4:3], 3'b000};
          res0.out_byte    = acc_word[ACC_W-1 -: BYTE_WIDTH];
          res0.last        = (total_bits[4:3] == 2'd1);
          res1.out_byte    = acc_word[ACC_W-BYTE_WIDTH-1 -: BYTE_WIDTH];
          res1.last        = 1'b1;
          partial_byte_next = acc_rest[ACC_W-1 -: BYTE_WIDTH];
          filled_bits_next  = total_bits[2:0];
        end
      end
      CMD_FLUSH: begin
        // nothing to emit at an exact byte boundary
        if (filled_bits != '0) begin
          n_res             = 2'd1;
          res0.out_byte     = partial_byte;
          res0.pad_bits     = 3'd0 - filled_bits;
          res0.last         = 1'b1;
          partial_byte_next = '0;
          filled_bits_next  = '0;
        end
      end
      default: begin
        // loads finished in stage 0; unused command code does nothing
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // two-entry result buffer feeding the byte-wide result port
  // ---------------------------------------------------------------------------
  logic [1:0] r_cnt;
  logic [1:0] r_cnt_eff;
  logic       out_acc;
  out_item_t  r0, r1;

  assign out_valid = (r_cnt != 2'd0);
  assign out_item  = r0;
  assign out_acc   = out_valid && out_ready;
  assign r_cnt_eff = r_cnt - {1'b0, out_acc};

  // stage 1 moves on when its results fit behind what stays in the buffer
  assign s1_adv   = s1_valid && ({1'b0, r_cnt_eff} + {1'b0, n_res} <= 3'd2);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt        <= 2'd0;
      partial_byte <= '0;
      filled_bits  <= '0;
    end else begin
      r_cnt <= s1_adv ? (r_cnt_eff + n_res) : r_cnt_eff;
      if (s1_adv) begin
        partial_byte <= partial_byte_next;
        filled_bits  <= filled_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc && (r_cnt == 2'd2)) begin
      r0 <= r1;
    end
    if (s1_adv && (n_res != 2'd0)) begin
      if (r_cnt_eff == 2'd0) begin
        r0 <= res0;
        r1 <= res1;
      end else begin
        r1 <= res0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/hcbp_checker.sv
// ----------------------------------------------------------------------------
// hcbp_checker: port-level assertions for the huffman code bit packer
// watches both transaction channels and is bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input hcbp_pkg::in_item_t  in_item,
  input wire                 out_valid,
  input wire                 out_ready,
  input hcbp_pkg::out_item_t out_item
);

  import hcbp_pkg::*;

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input changed while stalled");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // padding only appears on the final byte of a flush
  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.pad_bits != 3'd0) |-> out_item.last)
    else $error("padding on a non-final byte");

  // input backpressure only arises while results are waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

>>> tb/huffman_code_bit_packer_core_test.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core_test: self-checking bench for the bit packer
// drives table loads, encodes, flushes and unused commands over valid/ready,
// predicts every packed byte in a local model of the code table and byte
// accumulator, and checks each output transaction in order
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam int MAX_LEN = 16;
  localparam int SYM_COUNT = 256;
  // longest code the table keeps; longer lengths saturate to this
  localparam int LEN_LIMIT = (MAX_LEN < CODE_WIDTH) ? MAX_LEN : CODE_WIDTH;
  // the command encoding leaves one value unused; the core must ignore it
  localparam cmd_t CMD_UNUSED = cmd_t'(2'd3);
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int RANDOM_CHUNKS = 7;
  localparam int CHUNK_ITEMS = 150;
  localparam int STEADY_ITEMS = 300;
  localparam int FILL_ITEMS = 48;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // local copy of the code table and the pending bits of the packer
  bit [CODE_WIDTH-1:0] code_tbl [SYM_COUNT];
  int unsigned         len_tbl [SYM_COUNT];
  bit [7:0]            pend_bits;   // right-aligned pending code bits
  int unsigned         pend_count;  // number of pending bits, 0..7

  out_item_t packed_bytes_q[$];

  int     errors = 0;
  int     n_load = 0, n_encode = 0, n_flush = 0, n_unused = 0;
  int     n_bytes = 0, n_flush_bytes = 0;
  bit     src_idle_en = 1'b0;
  bit     sink_idle_en = 1'b0;
  bit     hold_outputs = 1'b0;
  longint cycle_count = 0;

  huffman_code_bit_packer_core #(
    .MAX_CODE_LEN(MAX_LEN),
    .SYMBOL_COUNT(SYM_COUNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #2 clk = ~clk;

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // packing predictor: applies one accepted input transaction and queues the
  // bytes it must produce; the last byte of each transaction carries last
  // ---------------------------------------------------------------------------
  function automatic void predict_packing(input in_item_t it);
    int unsigned nbits, total;
    bit [31:0]   acc, shifted;
    out_item_t   held, res;
    int          n;
    n = 0;
    held = '0;
    res = '0;
    case (it.cmd)
      CMD_LOAD: begin
        n_load++;
        nbits = (it.code_length > LEN_LIMIT) ? LEN_LIMIT : it.code_length;
        acc = it.code_bits & ((32'd1 << nbits) - 1);
        len_tbl[it.symbol] = nbits;
        code_tbl[it.symbol] = acc[CODE_WIDTH-1:0];
      end
      CMD_ENCODE: begin
        n_encode++;
        nbits = len_tbl[it.symbol];
        acc = (32'(pend_bits) << nbits) | 32'(code_tbl[it.symbol]);
        total = pend_count + nbits;
        // hold each byte back until we know whether another one follows
        while (total >= 8) begin
          shifted = acc >> (total - 8);
          res.out_byte = shifted[7:0];
          res.pad_bits = '0;
          res.last = 1'b0;
          if (n > 0) packed_bytes_q.push_back(held);
          held = res;
          n++;
          total -= 8;
        end
        if (n > 0) begin
          held.last = 1'b1;
          packed_bytes_q.push_back(held);
        end
        acc &= (32'd1 << total) - 1;
        pend_bits = acc[7:0];
        pend_count = total;
      end
      CMD_FLUSH: begin
        n_flush++;
        // at a byte boundary there is nothing to flush
        if (pend_count != 0) begin
          res.out_byte = 8'(pend_bits << (8 - pend_count));
          res.pad_bits = 3'(8 - pend_count);
          res.last = 1'b1;
          packed_bytes_q.push_back(res);
          pend_bits = '0;
          pend_count = 0;
        end
      end
      default: n_unused++;
    endcase
  endfunction

  function automatic in_item_t make_item(input cmd_t cmd, input logic [7:0] sym,
                                         input logic [15:0] bits, input logic [4:0] len);
    in_item_t it;
    it.cmd = cmd;
    it.symbol = sym;
    it.code_bits = bits;
    it.code_length = len;
    return it;
  endfunction

  // mostly legal lengths, some zero and some beyond the saturation bound
  function automatic logic [4:0] random_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return 5'd0;
    if (pick < 10) return 5'($urandom_range(LEN_LIMIT + 1, 31));
    return 5'($urandom_range(1, LEN_LIMIT));
  endfunction

  // random traffic: mostly encodes, with reloads, flushes and unused commands
  function automatic in_item_t random_item();
    int unsigned pick;
    in_item_t    it;
    pick = $urandom_range(0, 99);
    it = make_item(CMD_ENCODE, 8'($urandom), 16'($urandom), 5'($urandom));
    if (pick < 10) begin
      it.cmd = CMD_LOAD;
      it.code_length = random_length();
    end else if (pick < 17) begin
      it.cmd = CMD_FLUSH;
    end else if (pick < 20) begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers one transaction at a falling edge, optionally after an idle
  // burst, and keeps it steady until accepted at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predict_packing(it);
  endtask

  // stop offering, wait for every expected byte, then let the pipe settle
  task automatic wait_drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (packed_bytes_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (packed_bytes_q.size() != 0) begin
      $error("%0d expected bytes never arrived", packed_bytes_q.size());
      errors += packed_bytes_q.size();
      packed_bytes_q.delete();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, or one long hold-off when requested
  // ---------------------------------------------------------------------------
  always begin
    @(negedge clk);
    if (hold_outputs) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      out_ready <= 1'b1;
      hold_outputs = 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each output transaction against the oldest expected byte
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (packed_bytes_q.size() == 0) begin
        $error("unexpected output byte %02h", out_item.out_byte);
        errors++;
      end else begin
        want = packed_bytes_q.pop_front();
        n_bytes++;
        if (want.pad_bits != 0) n_flush_bytes++;
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, out_item.out_byte);
          errors++;
        end
        if (out_item.pad_bits !== want.pad_bits) begin
          $error("pad_bits: expected %0d, actual %0d", want.pad_bits, out_item.pad_bits);
          errors++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_item.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner cases: byte boundary flush, saturation, zero length, dropped bits
  task automatic test_directed_cases();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    send_item(make_item(CMD_FLUSH, 8'h00, 16'h0000, 5'd0));     // nothing pending
    send_item(make_item(CMD_LOAD, 8'h00, 16'hFFFF, 5'd16));     // all ones, full length
    send_item(make_item(CMD_LOAD, 8'hFF, 16'h0000, 5'd16));     // all zeros, full length
    send_item(make_item(CMD_LOAD, 8'h01, 16'hFFFF, 5'd1));      // upper code bits dropped
    send_item(make_item(CMD_LOAD, 8'h02, 16'hA5C3, 5'd31));     // overlong, saturates
    send_item(make_item(CMD_LOAD, 8'h03, 16'h1234, 5'd0));      // zero length entry
    send_item(make_item(CMD_LOAD, 8'h80, 16'hFFFD, 5'd3));
    send_item(make_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 5'h1F));   // must be ignored
    send_item(make_item(CMD_ENCODE, 8'h01, 16'hFFFF, 5'h1F));
    send_item(make_item(CMD_FLUSH, 8'hFF, 16'hFFFF, 5'h1F));    // seven pad bits
    send_item(make_item(CMD_ENCODE, 8'h00, 16'h0000, 5'd0));    // two bytes from empty
    send_item(make_item(CMD_ENCODE, 8'h03, 16'h0000, 5'd0));    // no bits appended
    send_item(make_item(CMD_ENCODE, 8'h80, 16'h0000, 5'd0));
    repeat (4) send_item(make_item(CMD_ENCODE, 8'h01, 16'h0000, 5'd0));
    send_item(make_item(CMD_ENCODE, 8'h00, 16'h0000, 5'd0));    // 7 + 16 bits
    send_item(make_item(CMD_ENCODE, 8'h02, 16'h0000, 5'd0));
    send_item(make_item(CMD_ENCODE, 8'hFF, 16'h0000, 5'd0));
    send_item(make_item(CMD_LOAD, 8'h04, 16'h002B, 5'd6));      // load, then use at once
    send_item(make_item(CMD_ENCODE, 8'h04, 16'h0000, 5'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 16'h0000, 5'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 16'h0000, 5'd0));     // back at a boundary
    wait_drain();
  endtask

  // every entry gets written before random encodes may touch it
  task automatic test_full_table();
    int s;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    for (s = 0; s < SYM_COUNT; s++)
      send_item(make_item(CMD_LOAD, 8'(s), 16'($urandom), random_length()));
    wait_drain();
  endtask

  // random traffic in chunks, each with its own mix of idling on both sides
  task automatic test_random_traffic();
    int c;
    for (c = 0; c < RANDOM_CHUNKS; c++) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      repeat (CHUNK_ITEMS) send_item(random_item());
      if (c % 3 == 2) wait_drain();
    end
    wait_drain();
  endtask

  // receiver holds off long enough for the core to fill and block its input
  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    hold_outputs = 1'b1;
    repeat (FILL_ITEMS)
      send_item(make_item(CMD_ENCODE, 8'($urandom), 16'($urandom), 5'($urandom)));
    wait_drain();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (STEADY_ITEMS) send_item(random_item());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_table();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();
    wait_drain();

    $display("run covered %0d loads, %0d encodes, %0d flushes, %0d unused commands",
             n_load, n_encode, n_flush, n_unused);
    $display("checked %0d packed bytes, %0d of them padded flush bytes, %0d errors",
             n_bytes, n_flush_bytes, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
